FILE: design/kce_pkg.sv
// shared types and constants of the keyframe curve evaluator
`default_nettype none

package kce_pkg;

   localparam int KCE_KEYS = 64;
   localparam int KCE_KEY_WIDTH = 128;
   localparam logic [16:0] ONE_Q = 17'h10000;

   typedef enum logic [1:0] {
      OP_WRITE_KEY = 2'd0,
      OP_SET_TIME  = 2'd1,
      OP_TICK      = 2'd2,
      OP_EVAL      = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_KEY_COUNT   = 1'b0,
      CSR_INTERP_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] time_arg;
      logic [5:0]         key_slot;
      logic signed [31:0] key_level;
      logic signed [31:0] key_in_slope;
      logic signed [31:0] key_out_slope;
   } req_type;

   typedef struct packed {
      logic signed [31:0] curve_value;
      logic [16:0]        segment_progress;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key_time;
      logic signed [31:0] key_level;
      logic signed [31:0] key_in_slope;
      logic signed [31:0] key_out_slope;
   } key_entry_type;

endpackage

`default_nettype wire

FILE: design/kce_ram.sv
// generic single write, single registered read ram
`default_nettype none

module kce_ram
   import kce_pkg::*;
#(
   parameter int WIDTH = KCE_KEY_WIDTH,
   parameter int DEPTH = KCE_KEYS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/kce_div.sv
// serial divider, one quotient bit per cycle, numerator below denominator
`default_nettype none

module kce_div
   import kce_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] num,
   input  wire logic [32:0] den,
   output logic             done,
   output logic [15:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic [33:0] r2;
   logic        ge;

   always_comb begin
      r2 = {rem_ff, 1'b0};
      ge = (r2 >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 4'd0;
         rem_in = num;
         den_in = den;
      end else if (busy_ff) begin
         rem_in = ge ? 33'(r2 - {1'b0, den_ff}) : r2[32:0];
         q_in = {q_ff[14:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

FILE: design/keyframe_curve_evaluator_core.sv
// keyframe curve evaluator top level: key table scan, divide and bezier blend
//
//   port group  dir  handshake             contents
//   req_        in   req_valid/req_stall   req_type: operation and key or time
//   rsp_        out  rsp_valid/rsp_stall   rsp_type: curve value and progress
//   csr_        in   csr_valid/csr_ready   key_count, interp_mode
//
// key write and set time are done in the idle state; tick and evaluate run
// the one-entry-per-cycle table scan over the n keys in use, up to two serial
// divides and a 22-step shared multiplier sequence
// reset is synchronous and clears current time and both registers; the key
// table is not cleared
// a finished result waits in the output register while the next item is taken
`default_nettype none

module keyframe_curve_evaluator_core
   import kce_pkg::*;
#(
   parameter int KEYS = KCE_KEYS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   localparam int AW = $clog2(KEYS);
   localparam int CW = $clog2(KEYS + 1);
   localparam int NW = (CW > 7) ? CW : 7;
   localparam int VW = 50;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SCAN = 9'b000000010,
      ST_POST = 9'b000000100,
      ST_DIVP = 9'b000001000,
      ST_PREA = 9'b000010000,
      ST_DIVA = 9'b000100000,
      ST_MULT = 9'b001000000,
      ST_MAC  = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

   function automatic logic signed [63:0] tdiv(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + (x[63] ? 64'sd65535 : 64'sd0);
      return y >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic signed [31:0] cur_ff, cur_in;
   logic [6:0]         kc_ff, kc_in;
   logic               mode_ff, mode_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [31:0] t_ff, t_in;
   logic [NW-1:0]      n_ff, n_in, n_calc;
   logic [NW-1:0]      iss_ff, iss_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               first_ff, first_in;
   logic               has_l_ff, has_l_in, has_r_ff, has_r_in;
   logic signed [31:0] lt_ff, lt_in, lv_ff, lv_in, lo_ff, lo_in;
   logic signed [31:0] rt_ff, rt_in, rval_ff, rval_in, rin_ff, rin_in;
   logic               pfound_ff, pfound_in;
   logic signed [31:0] pstart_ff, pstart_in, pend_ff, pend_in, prev_ff, prev_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic [16:0]        res_prog_ff, res_prog_in;
   logic               cubic_ff, cubic_in;
   logic [31:0]        span_ff, span_in;
   logic [32:0]        off_ff, off_in;
   logic [16:0]        a_ff, a_in, b_ff, b_in;
   logic [16:0]        a2_ff, a2_in, a3_ff, a3_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [17:0]        c1_ff, c1_in, c2_ff, c2_in;
   logic signed [VW-1:0] v2_ff, v2_in, v3_ff, v3_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [3:0]         step_ff, step_in;
   logic [1:0]         term_ff, term_in, chunk_ff, chunk_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   key_entry_type      wr_entry, rd_entry;
   logic [32:0]        tick_sum;
   logic signed [31:0] tick_val;
   logic signed [32:0] pd_raw, pn_raw, pd, pn;
   logic               div_start, div_done;
   logic [32:0]        div_num, div_den;
   logic [15:0]        div_q;
   logic signed [32:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [51:0] prod;
   logic signed [63:0] prod64;
   logic signed [63:0] vx;
   logic [17:0]        coef;
   logic [16:0]        prod_hi;
   logic               out_free;
   logic signed [31:0] fin_val;

   kce_ram #(
      .WIDTH ($bits(key_entry_type)),
      .DEPTH (KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   kce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign n_calc = (NW'(kc_ff) > NW'(KEYS)) ? NW'(KEYS) : NW'(kc_ff);
   assign tick_sum = {cur_ff[31], cur_ff} + {req_data.time_arg[31], req_data.time_arg};
   assign tick_val = (tick_sum[32] != tick_sum[31]) ?
                     (tick_sum[32] ? 32'sh80000000 : 32'sh7fffffff) : tick_sum[31:0];
   assign wr_addr = AW'(req_data.key_slot);
   assign wr_entry = '{key_time: req_data.time_arg, key_level: req_data.key_level,
                       key_in_slope: req_data.key_in_slope,
                       key_out_slope: req_data.key_out_slope};

   assign pd_raw = {pend_ff[31], pend_ff} - {pstart_ff[31], pstart_ff};
   assign pn_raw = {t_ff[31], t_ff} - {pstart_ff[31], pstart_ff};
   assign pd = pd_raw[32] ? -pd_raw : pd_raw;
   assign pn = pd_raw[32] ? -pn_raw : pn_raw;

   // shared multiplier operand select
   always_comb begin
      vx = 64'sd0;
      coef = 18'd0;
      mul_a = 33'sd0;
      mul_b = 19'sd0;
      unique case (term_ff)
         2'd0: begin
            vx = 64'(lv_ff);
            coef = {1'b0, b3_ff};
         end
         2'd1: begin
            vx = 64'(v2_ff);
            coef = c1_ff;
         end
         2'd2: begin
            vx = 64'(v3_ff);
            coef = c2_ff;
         end
         default: begin
            vx = 64'(rval_ff);
            coef = {1'b0, a3_ff};
         end
      endcase
      if (state_ff == ST_MAC) begin
         mul_b = {1'b0, coef};
         priority case (chunk_ff)
            2'd0: mul_a = {17'd0, vx[15:0]};
            2'd1: mul_a = {17'd0, vx[31:16]};
            default: mul_a = 33'($signed(vx[63:32]));
         endcase
      end else begin
         unique case (step_ff)
            4'd0, 4'd1: begin
               mul_a = 33'(lo_ff);
               mul_b = {3'd0, (step_ff == 4'd0) ? span_ff[15:0] : span_ff[31:16]};
            end
            4'd2, 4'd3: begin
               mul_a = 33'(rin_ff);
               mul_b = {3'd0, (step_ff == 4'd2) ? span_ff[15:0] : span_ff[31:16]};
            end
            4'd4: begin
               mul_a = {16'd0, b_ff};
               mul_b = {2'd0, b_ff};
            end
            4'd5: begin
               mul_a = {16'd0, b_ff};
               mul_b = {2'd0, b2_ff};
            end
            4'd6: begin
               mul_a = {16'd0, a_ff};
               mul_b = {2'd0, a_ff};
            end
            4'd7: begin
               mul_a = {16'd0, a2_ff};
               mul_b = {2'd0, a_ff};
            end
            4'd8: begin
               mul_a = {16'd0, b2_ff};
               mul_b = {2'd0, a_ff};
            end
            4'd9: begin
               mul_a = {16'd0, a2_ff};
               mul_b = {2'd0, b_ff};
            end
            default: begin
               mul_a = 33'sd0;
               mul_b = 19'sd0;
            end
         endcase
      end
   end

   assign prod = mul_a * mul_b;
   assign prod64 = 64'(prod);
   assign prod_hi = prod[32:16];
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign fin_val = cubic_ff ? sat32(tdiv(acc_ff)) : res_val_ff;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      kc_in = kc_ff;
      mode_in = mode_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      t_in = t_ff;
      n_in = n_ff;
      iss_in = iss_ff;
      rd_vld_in = 1'b0;
      first_in = first_ff;
      has_l_in = has_l_ff;
      has_r_in = has_r_ff;
      lt_in = lt_ff;
      lv_in = lv_ff;
      lo_in = lo_ff;
      rt_in = rt_ff;
      rval_in = rval_ff;
      rin_in = rin_ff;
      pfound_in = pfound_ff;
      pstart_in = pstart_ff;
      pend_in = pend_ff;
      prev_in = prev_ff;
      res_val_in = res_val_ff;
      res_prog_in = res_prog_ff;
      cubic_in = cubic_ff;
      span_in = span_ff;
      off_in = off_ff;
      a_in = a_ff;
      b_in = b_ff;
      a2_in = a2_ff;
      a3_in = a3_ff;
      b2_in = b2_ff;
      b3_in = b3_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      term_in = term_ff;
      chunk_in = chunk_ff;
      wr_en = 1'b0;
      div_start = 1'b0;
      div_num = 33'd0;
      div_den = 33'd0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_COUNT:   kc_in = csr_data;
            CSR_INTERP_MODE: mode_in = csr_data[0];
            default:         kc_in = kc_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == OP_WRITE_KEY) begin
                  wr_en = (32'(req_data.key_slot) < 32'(KEYS));
               end else if (req_data.operation == OP_SET_TIME) begin
                  cur_in = req_data.time_arg;
               end else begin
                  if (req_data.operation == OP_TICK) begin
                     cur_in = tick_val;
                     t_in = tick_val;
                  end else begin
                     t_in = req_data.time_arg;
                  end
                  n_in = n_calc;
                  iss_in = '0;
                  first_in = 1'b1;
                  has_l_in = 1'b0;
                  has_r_in = 1'b0;
                  pfound_in = 1'b0;
                  cubic_in = 1'b0;
                  res_val_in = 32'sd0;
                  res_prog_in = 17'd0;
                  state_in = (n_calc == '0) ? ST_FIN : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (iss_ff < n_ff) begin
               iss_in = iss_ff + NW'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = ST_POST;
            end
            if (rd_vld_ff) begin
               if (rd_entry.key_time <= t_ff) begin
                  if (!has_l_ff || rd_entry.key_time > lt_ff) begin
                     has_l_in = 1'b1;
                     lt_in = rd_entry.key_time;
                     lv_in = rd_entry.key_level;
                     lo_in = rd_entry.key_out_slope;
                  end
               end else if (!has_r_ff || rd_entry.key_time < rt_ff) begin
                  has_r_in = 1'b1;
                  rt_in = rd_entry.key_time;
                  rval_in = rd_entry.key_level;
                  rin_in = rd_entry.key_in_slope;
               end
               if (!pfound_ff && rd_entry.key_time > t_ff) begin
                  pfound_in = 1'b1;
                  pstart_in = first_ff ? rd_entry.key_time : prev_ff;
                  pend_in = rd_entry.key_time;
               end
               prev_in = rd_entry.key_time;
               first_in = 1'b0;
            end
         end
         ST_POST: begin
            cubic_in = has_l_ff && has_r_ff && !mode_ff;
            res_val_in = has_l_ff ? lv_ff : rval_ff;
            span_in = 32'({rt_ff[31], rt_ff} - {lt_ff[31], lt_ff});
            off_in = {t_ff[31], t_ff} - {lt_ff[31], lt_ff};
            state_in = ST_PREA;
            if (!pfound_ff) begin
               res_prog_in = ONE_Q;
            end else if (pd == 33'sd0 || pn <= 33'sd0) begin
               res_prog_in = 17'd0;
            end else if (pn >= pd) begin
               res_prog_in = ONE_Q;
            end else begin
               div_start = 1'b1;
               div_num = pn;
               div_den = pd;
               state_in = ST_DIVP;
            end
         end
         ST_DIVP: begin
            if (div_done) begin
               res_prog_in = {1'b0, div_q};
               state_in = ST_PREA;
            end
         end
         ST_PREA: begin
            if (!cubic_ff) begin
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               div_num = off_ff;
               div_den = {1'b0, span_ff};
               state_in = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               a_in = {1'b0, div_q};
               b_in = ONE_Q - {1'b0, div_q};
               step_in = 4'd0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               4'd0: acc_in = prod64;
               4'd1: acc_in = acc_ff + (prod64 <<< 16);
               4'd2: begin
                  v2_in = VW'(64'(lv_ff) + tdiv(acc_ff));
                  acc_in = prod64;
               end
               4'd3: acc_in = acc_ff + (prod64 <<< 16);
               4'd4: begin
                  v3_in = VW'(64'(rval_ff) - tdiv(acc_ff));
                  b2_in = prod_hi;
               end
               4'd5: b3_in = prod_hi;
               4'd6: a2_in = prod_hi;
               4'd7: a3_in = prod_hi;
               4'd8: c1_in = {1'b0, prod_hi} + {prod_hi, 1'b0};
               4'd9: begin
                  c2_in = {1'b0, prod_hi} + {prod_hi, 1'b0};
                  acc_in = 64'sd0;
                  term_in = 2'd0;
                  chunk_in = 2'd0;
                  state_in = ST_MAC;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MAC: begin
            priority case (chunk_ff)
               2'd0: acc_in = acc_ff + prod64;
               2'd1: acc_in = acc_ff + (prod64 <<< 16);
               default: acc_in = acc_ff + (prod64 <<< 32);
            endcase
            if (chunk_ff == 2'd2) begin
               chunk_in = 2'd0;
               term_in = term_ff + 2'd1;
               if (term_ff == 2'd3) begin
                  state_in = ST_FIN;
               end
            end else begin
               chunk_in = chunk_ff + 2'd1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_data_in = '{curve_value: fin_val, segment_progress: res_prog_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= 32'sd0;
         kc_ff <= 7'd0;
         mode_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         kc_ff <= kc_in;
         mode_ff <= mode_in;
         rsp_vld_ff <= rsp_vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      t_ff <= t_in;
      n_ff <= n_in;
      iss_ff <= iss_in;
      first_ff <= first_in;
      has_l_ff <= has_l_in;
      has_r_ff <= has_r_in;
      lt_ff <= lt_in;
      lv_ff <= lv_in;
      lo_ff <= lo_in;
      rt_ff <= rt_in;
      rval_ff <= rval_in;
      rin_ff <= rin_in;
      pfound_ff <= pfound_in;
      pstart_ff <= pstart_in;
      pend_ff <= pend_in;
      prev_ff <= prev_in;
      res_val_ff <= res_val_in;
      res_prog_ff <= res_prog_in;
      cubic_ff <= cubic_in;
      span_ff <= span_in;
      off_ff <= off_in;
      a_ff <= a_in;
      b_ff <= b_in;
      a2_ff <= a2_in;
      a3_ff <= a3_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      v2_ff <= v2_in;
      v3_ff <= v3_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      term_ff <= term_in;
      chunk_ff <= chunk_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for the keyframe curve evaluator core
`timescale 1ns / 1ps

module tb_top;
   import kce_pkg::*;

   localparam int SETTLE_CYCLES = 200;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [0:0] csr_index;
   logic [6:0] csr_data;

   keyframe_curve_evaluator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predictor state
   logic signed [31:0] key_time_tab [KCE_KEYS];
   logic signed [31:0] key_level_tab [KCE_KEYS];
   logic signed [31:0] key_in_tab [KCE_KEYS];
   logic signed [31:0] key_out_tab [KCE_KEYS];
   logic signed [31:0] now_time;
   logic [6:0]         keys_used;
   logic               hold_mode;

   rsp_type expected_curve [$];
   int      error_count;
   int      burst_left;

   function automatic int active_keys();
      return (keys_used > KCE_KEYS) ? KCE_KEYS : int'(keys_used);
   endfunction

   function automatic logic signed [31:0] sat_q(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] curve_at(input logic signed [31:0] t);
      int     n, li, ri;
      bit     has_l, has_r;
      longint t1, span, v1, v2, v3, v4, a, b, a2, b2, a3, b3, c1, c2, total;
      n = active_keys();
      has_l = 0;
      has_r = 0;
      li = 0;
      ri = 0;
      if (n == 0) return 0;
      for (int i = 0; i < n; i++) begin
         if (key_time_tab[i] <= t) begin
            if (!has_l || key_time_tab[i] > key_time_tab[li]) begin
               li = i;
               has_l = 1;
            end
         end else begin
            if (!has_r || key_time_tab[i] < key_time_tab[ri]) begin
               ri = i;
               has_r = 1;
            end
         end
      end
      if (!has_l) return key_level_tab[ri];
      if (!has_r) return key_level_tab[li];
      if (hold_mode) return key_level_tab[li];
      t1 = key_time_tab[li];
      span = longint'(key_time_tab[ri]) - t1;
      v1 = key_level_tab[li];
      v4 = key_level_tab[ri];
      if (span <= 0) return sat_q((v1 + v4) / 2);
      a = ((longint'(t) - t1) <<< 16) / span;
      if (a > 65536) a = 65536;
      b = 65536 - a;
      v2 = v1 + (longint'(key_out_tab[li]) * span) / 65536;
      v3 = v4 - (longint'(key_in_tab[ri]) * span) / 65536;
      b2 = b * b / 65536;
      b3 = b * b2 / 65536;
      a2 = a * a / 65536;
      a3 = a2 * a / 65536;
      c1 = 3 * (b2 * a / 65536);
      c2 = 3 * (a2 * b / 65536);
      total = b3 * v1 + c1 * v2 + c2 * v3 + a3 * v4;
      return sat_q(total / 65536);
   endfunction

   function automatic logic [16:0] segment_fraction(input logic signed [31:0] t);
      int     n;
      longint start, den, num;
      n = active_keys();
      if (n == 0) return 0;
      start = key_time_tab[0];
      for (int i = 0; i < n; i++) begin
         if (key_time_tab[i] > t) begin
            den = longint'(key_time_tab[i]) - start;
            num = longint'(t) - start;
            if (den == 0) return 0;
            if (den < 0) begin
               den = -den;
               num = -num;
            end
            if (num <= 0) return 0;
            if (num >= den) return ONE_Q;
            return 17'((num <<< 16) / den);
         end
         start = key_time_tab[i];
      end
      return ONE_Q;
   endfunction

   function automatic void apply_item(input req_type r);
      logic signed [31:0] t;
      rsp_type            e;
      case (r.operation)
         OP_WRITE_KEY: begin
            key_time_tab[r.key_slot] = r.time_arg;
            key_level_tab[r.key_slot] = r.key_level;
            key_in_tab[r.key_slot] = r.key_in_slope;
            key_out_tab[r.key_slot] = r.key_out_slope;
         end
         OP_SET_TIME: now_time = r.time_arg;
         default: begin
            if (r.operation == OP_TICK) begin
               now_time = sat_q(longint'(now_time) + longint'(r.time_arg));
               t = now_time;
            end else begin
               t = r.time_arg;
            end
            e.curve_value = curve_at(t);
            e.segment_progress = segment_fraction(t);
            expected_curve.push_back(e);
         end
      endcase
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_curve.size() == 0) begin
            report("unexpected transfer", rsp_data.curve_value, 0);
         end else begin
            e = expected_curve.pop_front();
            if (rsp_data.curve_value !== e.curve_value)
               report("curve_value", rsp_data.curve_value, e.curve_value);
            if (rsp_data.segment_progress !== e.segment_progress)
               report("segment_progress", rsp_data.segment_progress, e.segment_progress);
         end
      end
   end

   // receiver stall pattern: runs of stall and free, sometimes long free stretches
   always @(posedge clock) begin
      static int run_left = 0;
      static bit stalling = 0;
      if (run_left == 0) begin
         stalling = ($urandom_range(0, 2) == 0) ? 1'b0 : ~stalling;
         run_left = stalling ? $urandom_range(1, 12) :
                    ($urandom_range(0, 4) == 0 ? $urandom_range(50, 300)
                                               : $urandom_range(1, 15));
      end
      run_left--;
      rsp_stall <= stalling;
   end

   task automatic send_item(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      apply_item(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 10) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 20);
      end
   endtask

   task automatic release_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      release_sender();
      while (expected_curve.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_COUNT) keys_used = val;
      else hold_mode = val[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(input op_type op, input logic signed [31:0] t,
                                        input logic [5:0] slot,
                                        input logic signed [31:0] lvl,
                                        input logic signed [31:0] sin,
                                        input logic signed [31:0] sout);
      req_type r;
      r.operation = op;
      r.time_arg = t;
      r.key_slot = slot;
      r.key_level = lvl;
      r.key_in_slope = sin;
      r.key_out_slope = sout;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_q(input bit wide);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return wide ? $urandom
                              : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   task automatic send_eval(input logic signed [31:0] t);
      send_item(make_req(OP_EVAL, t, 0, 0, 0, 0));
   endtask

   task automatic test_empty_table();
      send_eval(32'sh0001_0000);
      send_item(make_req(OP_TICK, 32'sh0000_8000, 6'h3f, -1, -1, -1));
      drain();
   endtask

   task automatic test_directed_keys();
      // unordered keys with a tie between slots 1 and 2
      send_item(make_req(OP_WRITE_KEY, 32'sh0004_0000, 0, 32'sh0010_0000,
                         32'sh0001_0000, 32'sh0002_0000));
      send_item(make_req(OP_WRITE_KEY, 32'sh0000_0000, 1, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff));
      send_item(make_req(OP_WRITE_KEY, 32'sh0000_0000, 2, 32'sh80000000,
                         32'sh7fffffff, 32'sh80000000));
      send_item(make_req(OP_WRITE_KEY, 32'sh7fffffff, 3, -32'sh0003_0000,
                         32'sh0000_0000, 32'sh0000_0000));
      send_item(make_req(OP_WRITE_KEY, 32'sh80000000, 63, 32'sh0000_1234,
                         -32'sh0001_0000, 32'sh0005_0000));
      drain();
      write_csr(CSR_KEY_COUNT, 7'd4);
      send_eval(32'sh80000000);
      send_eval(-32'sh0000_0001);
      send_eval(32'sh0000_0000);
      send_eval(32'sh0001_8000);
      send_eval(32'sh0004_0000);
      send_eval(32'sh7fffffff);
      send_eval(32'sh7ffffffe);
      send_item(make_req(OP_SET_TIME, 32'sh7fff_0000, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 32'sh7fffffff, 0, 0, 0, 0));
      send_item(make_req(OP_SET_TIME, 32'sh8000_1000, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 32'sh80000000, 0, 0, 0, 0));
      send_item(make_req(OP_TICK, 32'sh0003_0000, 0, 0, 0, 0));
      drain();
      write_csr(CSR_INTERP_MODE, 7'd1);
      send_eval(32'sh0002_0000);
      send_eval(32'sh7ffffff0);
      drain();
      write_csr(CSR_INTERP_MODE, 7'd0);
   endtask

   task automatic test_fill_table();
      for (int s = 0; s < KCE_KEYS; s++)
         send_item(make_req(OP_WRITE_KEY, rand_q(0), 6'(s), rand_q(1), rand_q(0),
                            rand_q(0)));
      drain();
   endtask

   task automatic test_random_mix(input int items, input logic [6:0] count,
                                  input bit mode);
      int pick;
      write_csr(CSR_KEY_COUNT, count);
      write_csr(CSR_INTERP_MODE, {6'd0, mode});
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            send_item(make_req(OP_WRITE_KEY, rand_q(0), 6'($urandom_range(0, 63)),
                               rand_q(1), rand_q(0), rand_q(0)));
         else if (pick < 20)
            send_item(make_req(OP_SET_TIME, rand_q(0), 6'($urandom), $urandom,
                               $urandom, $urandom));
         else if (pick < 55)
            send_item(make_req(OP_TICK, ($urandom_range(0, 15) == 0) ? rand_q(1)
                               : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0001_0000,
                               6'($urandom), $urandom, $urandom, $urandom));
         else
            send_item(make_req(OP_EVAL, rand_q(0), 6'($urandom), $urandom,
                               $urandom, $urandom));
      end
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      error_count = 0;
      burst_left = 0;
      now_time = 0;
      keys_used = 0;
      hold_mode = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed_keys();
      test_fill_table();
      test_random_mix(300, 7'd2, 1'b0);
      test_random_mix(300, 7'd8, 1'b0);
      test_random_mix(250, 7'd64, 1'b0);
      test_random_mix(200, 7'd1, 1'b0);
      test_random_mix(250, 7'd16, 1'b1);
      test_random_mix(200, 7'd127, 1'b0);
      test_random_mix(150, 7'd0, 1'b1);
      test_random_mix(200, 7'd5, 1'b0);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
